// ===== src/ifp_pkg.sv =====
// ============================================================================
// ifp_pkg
// Shared types, constants and helpers of the impact feedforward pulse block.
// ============================================================================
package ifp_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int JUMP_W      = SAMPLE_BITS + 1;
  localparam int CMP_W       = (JUMP_W > 16) ? JUMP_W : 16;

  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int TIMER_W     = 16;

  localparam int DRIVE_W     = 11;
  localparam int MAG_W       = 10;
  localparam int PROD_W      = MAG_W + TIMER_W;
  localparam int DIV_STEPS   = PROD_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  localparam logic signed [DRIVE_W:0]   OUT_LIMIT  = 12'sd600;
  localparam logic        [DRIVE_W:0]   MIN_CHANGE = 12'd5;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HOLD,
    PH_RAMP,
    PH_REARM
  } phase_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_LOWER,
    ACT_RAISE
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_JUMP_THRESHOLD,
    REG_QUIET_DELTA,
    REG_HOLD_TICKS,
    REG_RAMP_TICKS,
    REG_QUIET_TICKS,
    REG_SAMPLE_TIMEOUT,
    REG_LOWER_PULSE,
    REG_RAISE_PULSE
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV_START,
    ST_DIV,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic mul;
    logic div_start;
    logic finish;
  } ifp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
  } ifp_sts_t;

  function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
    sat_inc = (v == {TIMER_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic signed [DRIVE_W-1:0] clamp_drive(
    input logic signed [DRIVE_W:0] x
  );
    if (x > OUT_LIMIT) begin
      clamp_drive = DRIVE_W'(OUT_LIMIT);
    end else if (x < -OUT_LIMIT) begin
      clamp_drive = DRIVE_W'(-OUT_LIMIT);
    end else begin
      clamp_drive = x[DRIVE_W-1:0];
    end
  endfunction

endpackage

// ===== src/ifp_in_if.sv =====
// ============================================================================
// ifp_in_if
// Input request channel: tick or acceleration sample with allow flag.
// ============================================================================
interface ifp_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 mode;
  logic signed [ifp_pkg::SAMPLE_BITS-1:0] accel_sample;
  logic                                 allow;

  modport source (output valid, output mode, output accel_sample, output allow,
                  input ready);
  modport sink   (input valid, input mode, input accel_sample, input allow,
                  output ready);
endinterface

// ===== src/ifp_out_if.sv =====
// ============================================================================
// ifp_out_if
// Result request channel: applied drive and status.
// ============================================================================
interface ifp_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ifp_pkg::DRIVE_W-1:0] drive_x10;
  logic                               drive_updated;
  logic [1:0]                         phase;
  logic [1:0]                         last_action;
  logic [15:0]                        fire_count;

  modport source (output valid, output drive_x10, output drive_updated,
                  output phase, output last_action, output fire_count,
                  input ready);
  modport sink   (input valid, input drive_x10, input drive_updated,
                  input phase, input last_action, input fire_count,
                  output ready);
endinterface

// ===== src/ifp_div.sv =====
// ============================================================================
// ifp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module ifp_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ifp_pkg::PROD_W-1:0]   dividend,
  input  logic [ifp_pkg::TIMER_W-1:0]  divisor,
  output logic                         busy,
  output logic [ifp_pkg::PROD_W-1:0]   quotient
);

  logic                            busy_r, busy_nxt;
  logic [ifp_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ifp_pkg::TIMER_W-1:0]     rem_r, rem_nxt;
  logic [ifp_pkg::TIMER_W-1:0]     dvs_r, dvs_nxt;
  logic [ifp_pkg::PROD_W-1:0]      quo_r, quo_nxt;
  logic [ifp_pkg::TIMER_W:0]       rem_sh;
  logic [ifp_pkg::TIMER_W:0]       rem_sub;
  logic                            ge;

  assign rem_sh  = {rem_r, quo_r[ifp_pkg::PROD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign ge      = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ifp_pkg::DIV_CNT_W'(ifp_pkg::DIV_STEPS);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sub[ifp_pkg::TIMER_W-1:0] : rem_sh[ifp_pkg::TIMER_W-1:0];
      quo_nxt = {quo_r[ifp_pkg::PROD_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == ifp_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// ===== src/ifp_ctrl.sv =====
// ============================================================================
// ifp_ctrl
// Sequencer: accept, execute, optional multiply and divide, deliver.
// ============================================================================
module ifp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ifp_pkg::ifp_sts_t sts,
  output ifp_pkg::ifp_cmd_t cmd
);

  ifp_pkg::ctrl_state_t state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ifp_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = ifp_pkg::ST_EXEC;
      end
      ifp_pkg::ST_EXEC: begin
        state_nxt = sts.need_div ? ifp_pkg::ST_MUL : ifp_pkg::ST_FINISH;
      end
      ifp_pkg::ST_MUL: begin
        state_nxt = ifp_pkg::ST_DIV_START;
      end
      ifp_pkg::ST_DIV_START: begin
        state_nxt = ifp_pkg::ST_DIV;
      end
      ifp_pkg::ST_DIV: begin
        if (!sts.div_busy) state_nxt = ifp_pkg::ST_FINISH;
      end
      ifp_pkg::ST_FINISH: begin
        if (out_free) state_nxt = ifp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = ifp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ifp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ifp_pkg::ST_EXEC:      cmd.exec      = 1'b1;
      ifp_pkg::ST_MUL:       cmd.mul       = 1'b1;
      ifp_pkg::ST_DIV_START: cmd.div_start = 1'b1;
      ifp_pkg::ST_FINISH:    cmd.finish    = out_free;
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ifp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/ifp_datapath.sv =====
// ============================================================================
// ifp_datapath
// Configuration, pulse state, ramp multiply and drive apply logic.
// ============================================================================
module ifp_datapath (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  ifp_pkg::ifp_cmd_t                       cmd,
  output logic                                    need_div,
  input  logic                                    cfg_we,
  input  logic [ifp_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [ifp_pkg::CFG_W-1:0]               cfg_wdata,
  input  logic                                    in_mode,
  input  logic signed [ifp_pkg::SAMPLE_BITS-1:0]  in_accel_sample,
  input  logic                                    in_allow,
  output logic [ifp_pkg::PROD_W-1:0]              div_dividend,
  output logic [ifp_pkg::TIMER_W-1:0]             div_divisor,
  input  logic [ifp_pkg::PROD_W-1:0]              div_quotient,
  output logic signed [ifp_pkg::DRIVE_W-1:0]      out_drive_x10,
  output logic                                    out_drive_updated,
  output logic [1:0]                              out_phase,
  output logic [1:0]                              out_last_action,
  output logic [15:0]                             out_fire_count
);

  localparam int SB = ifp_pkg::SAMPLE_BITS;
  localparam int TW = ifp_pkg::TIMER_W;
  localparam int DW = ifp_pkg::DRIVE_W;
  localparam int MW = ifp_pkg::MAG_W;
  localparam int PW = ifp_pkg::PROD_W;
  localparam int JW = ifp_pkg::JUMP_W;
  localparam int CW = ifp_pkg::CMP_W;

  // configuration
  logic [TW-1:0]        thr_r, qd_r, hold_r, ramp_r, qtk_r, tmo_r;
  logic signed [DW-1:0] lower_r, raise_r;

  // latched request
  logic                 mode_r, allow_r;
  logic signed [SB-1:0] sample_r;

  // pulse state
  ifp_pkg::phase_t      phase_r, phase_nxt;
  ifp_pkg::action_t     action_r, action_nxt;
  logic [TW-1:0]        pt_r, pt_nxt, qt_r, qt_nxt, age_r, age_nxt;
  logic                 qrun_r, qrun_nxt, have_prev_r, have_prev_nxt, nir_r, nir_nxt;
  logic signed [SB-1:0] prev_r, prev_nxt;
  logic signed [DW-1:0] peak_r, peak_nxt, applied_r, applied_nxt;
  logic [15:0]          fc_r, fc_nxt;

  // working registers
  logic signed [DW-1:0] target_r, target_nxt;
  logic                 apply_en_r, apply_en_nxt, div_r, div_nxt;
  logic                 peak_neg_r, peak_neg_nxt;
  logic [MW-1:0]        mul_a_r, mul_a_nxt;
  logic [TW-1:0]        mul_b_r, mul_b_nxt;
  logic [PW-1:0]        prod_r;

  // result registers
  logic signed [DW-1:0] drive_o_r;
  logic                 upd_o_r;
  ifp_pkg::phase_t      phase_o_r;
  ifp_pkg::action_t     action_o_r;
  logic [15:0]          fc_o_r;

  logic [TW-1:0]        pt1, qt1, age1;
  logic                 cancel;
  logic signed [JW-1:0] jump;
  logic [JW-1:0]        mag;
  logic [CW-1:0]        mag_ext;
  logic signed [DW-1:0] peak_abs;
  logic signed [DW-1:0] peak_fire;

  logic signed [DW-1:0] qs;
  logic signed [DW-1:0] tgt;
  logic signed [DW:0]   diff;
  logic [DW:0]          diff_abs;
  logic                 upd;

  assign pt1    = ifp_pkg::sat_inc(pt_r);
  assign qt1    = ifp_pkg::sat_inc(qt_r);
  assign age1   = ifp_pkg::sat_inc(age_r);
  assign cancel = !allow_r || (have_prev_r && (age1 > tmo_r));

  assign jump     = {sample_r[SB-1], sample_r} - {prev_r[SB-1], prev_r};
  assign mag      = jump[JW-1] ? (~jump + 1'b1) : jump;
  assign mag_ext  = CW'(mag);
  assign peak_abs = peak_r[DW-1] ? -peak_r : peak_r;
  assign peak_fire = nir_r ? ifp_pkg::clamp_drive(-{raise_r[DW-1], raise_r})
                           : ifp_pkg::clamp_drive({lower_r[DW-1], lower_r});

  always_comb begin
    phase_nxt     = phase_r;
    action_nxt    = action_r;
    pt_nxt        = pt_r;
    qt_nxt        = qt_r;
    age_nxt       = age_r;
    qrun_nxt      = qrun_r;
    have_prev_nxt = have_prev_r;
    nir_nxt       = nir_r;
    prev_nxt      = prev_r;
    peak_nxt      = peak_r;
    fc_nxt        = fc_r;
    target_nxt    = target_r;
    apply_en_nxt  = apply_en_r;
    div_nxt       = div_r;
    peak_neg_nxt  = peak_neg_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    need_div      = 1'b0;
    if (cmd.exec) begin
      div_nxt = 1'b0;
      if (!mode_r) begin
        apply_en_nxt = 1'b1;
        target_nxt   = '0;
        pt_nxt       = pt1;
        qt_nxt       = qt1;
        age_nxt      = age1;
        if (cancel) begin
          phase_nxt     = ifp_pkg::PH_IDLE;
          pt_nxt        = '0;
          qt_nxt        = '0;
          qrun_nxt      = 1'b0;
          peak_nxt      = '0;
          have_prev_nxt = 1'b0;
        end else begin
          case (phase_r)
            ifp_pkg::PH_HOLD: begin
              target_nxt = peak_r;
              if (pt1 >= hold_r) begin
                phase_nxt = ifp_pkg::PH_RAMP;
                pt_nxt    = '0;
              end
            end
            ifp_pkg::PH_RAMP: begin
              if (pt1 < ramp_r) begin
                need_div     = 1'b1;
                div_nxt      = 1'b1;
                peak_neg_nxt = peak_r[DW-1];
                mul_a_nxt    = peak_abs[MW-1:0];
                mul_b_nxt    = ramp_r - pt1;
              end else begin
                phase_nxt = ifp_pkg::PH_REARM;
                pt_nxt    = '0;
                qt_nxt    = '0;
                qrun_nxt  = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end else begin
        apply_en_nxt = 1'b0;
        age_nxt      = '0;
        prev_nxt     = sample_r;
        if (!have_prev_r) begin
          have_prev_nxt = 1'b1;
        end else begin
          case (phase_r)
            ifp_pkg::PH_IDLE: begin
              if (allow_r && (mag_ext > CW'(thr_r))) begin
                action_nxt   = nir_r ? ifp_pkg::ACT_RAISE : ifp_pkg::ACT_LOWER;
                nir_nxt      = !nir_r;
                peak_nxt     = peak_fire;
                phase_nxt    = ifp_pkg::PH_HOLD;
                pt_nxt       = '0;
                qt_nxt       = '0;
                qrun_nxt     = 1'b0;
                fc_nxt       = fc_r + 1'b1;
                apply_en_nxt = 1'b1;
                target_nxt   = peak_fire;
              end
            end
            ifp_pkg::PH_REARM: begin
              if (mag_ext <= CW'(qd_r)) begin
                if (!qrun_r) begin
                  qrun_nxt = 1'b1;
                  qt_nxt   = '0;
                end else if (qt_r >= qtk_r) begin
                  phase_nxt = ifp_pkg::PH_IDLE;
                  pt_nxt    = '0;
                  qrun_nxt  = 1'b0;
                  qt_nxt    = '0;
                end
              end else begin
                qrun_nxt = 1'b0;
                qt_nxt   = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  // drive apply with the minimum-change rule
  assign qs       = {1'b0, div_quotient[MW-1:0]};
  assign tgt      = div_r ? (peak_neg_r ? -qs : qs) : target_r;
  assign diff     = {tgt[DW-1], tgt} - {applied_r[DW-1], applied_r};
  assign diff_abs = diff[DW] ? (~diff + 1'b1) : diff;

  always_comb begin
    upd = 1'b0;
    if (apply_en_r) begin
      if (tgt == '0) begin
        upd = (applied_r != '0);
      end else begin
        upd = (diff_abs >= ifp_pkg::MIN_CHANGE);
      end
    end
    applied_nxt = (cmd.finish && upd) ? tgt : applied_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= 16'd80;
      qd_r        <= 16'd20;
      hold_r      <= 16'd100;
      ramp_r      <= 16'd150;
      qtk_r       <= 16'd2000;
      tmo_r       <= 16'd150;
      lower_r     <= 11'sd250;
      raise_r     <= 11'sd250;
      phase_r     <= ifp_pkg::PH_IDLE;
      action_r    <= ifp_pkg::ACT_NONE;
      pt_r        <= '0;
      qt_r        <= '0;
      age_r       <= '0;
      qrun_r      <= 1'b0;
      have_prev_r <= 1'b0;
      nir_r       <= 1'b0;
      prev_r      <= '0;
      peak_r      <= '0;
      applied_r   <= '0;
      fc_r        <= '0;
    end else begin
      if (cfg_we) begin
        case (ifp_pkg::cfg_reg_t'(cfg_index))
          ifp_pkg::REG_JUMP_THRESHOLD: thr_r   <= cfg_wdata;
          ifp_pkg::REG_QUIET_DELTA:    qd_r    <= cfg_wdata;
          ifp_pkg::REG_HOLD_TICKS:     hold_r  <= cfg_wdata;
          ifp_pkg::REG_RAMP_TICKS:     ramp_r  <= cfg_wdata;
          ifp_pkg::REG_QUIET_TICKS:    qtk_r   <= cfg_wdata;
          ifp_pkg::REG_SAMPLE_TIMEOUT: tmo_r   <= cfg_wdata;
          ifp_pkg::REG_LOWER_PULSE:    lower_r <= cfg_wdata[DW-1:0];
          ifp_pkg::REG_RAISE_PULSE:    raise_r <= cfg_wdata[DW-1:0];
          default: begin
          end
        endcase
      end
      phase_r     <= phase_nxt;
      action_r    <= action_nxt;
      pt_r        <= pt_nxt;
      qt_r        <= qt_nxt;
      age_r       <= age_nxt;
      qrun_r      <= qrun_nxt;
      have_prev_r <= have_prev_nxt;
      nir_r       <= nir_nxt;
      prev_r      <= prev_nxt;
      peak_r      <= peak_nxt;
      applied_r   <= applied_nxt;
      fc_r        <= fc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_mode;
      sample_r <= in_accel_sample;
      allow_r  <= in_allow;
    end
    target_r   <= target_nxt;
    apply_en_r <= apply_en_nxt;
    div_r      <= div_nxt;
    peak_neg_r <= peak_neg_nxt;
    mul_a_r    <= mul_a_nxt;
    mul_b_r    <= mul_b_nxt;
    if (cmd.mul) begin
      prod_r <= PW'(mul_a_r) * PW'(mul_b_r);
    end
    if (cmd.finish) begin
      drive_o_r  <= applied_nxt;
      upd_o_r    <= upd;
      phase_o_r  <= phase_r;
      action_o_r <= action_r;
      fc_o_r     <= fc_r;
    end
  end

  assign div_dividend      = prod_r;
  assign div_divisor       = ramp_r;
  assign out_drive_x10     = drive_o_r;
  assign out_drive_updated = upd_o_r;
  assign out_phase         = phase_o_r;
  assign out_last_action   = action_o_r;
  assign out_fire_count    = fc_o_r;

endmodule

// ===== src/impact_feedforward_pulse.sv =====
// ============================================================================
// impact_feedforward_pulse
// Impact feedforward pulse generator, top level.
// ============================================================================
// One request is taken at a time. A request passes the execute and finish
// states before the next is accepted; a ramp tick also passes the multiply,
// divide-start and divide states, where the 26-step restoring divider forms
// the ramp value. Each request gives one result, held in an output register
// so the next request may be taken while the result waits; a result still
// waiting when the next one is ready holds the block in its finish state.
// The user must write configuration through cfg_we/cfg_index/cfg_wdata
// while no request is in flight; the block itself does not enforce this.
module impact_feedforward_pulse (
  input  logic                               clk,
  input  logic                               rst_n,
  ifp_in_if.sink                             in_ch,
  ifp_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [ifp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ifp_pkg::CFG_W-1:0]          cfg_wdata
);

  ifp_pkg::ifp_cmd_t               cmd;
  ifp_pkg::ifp_sts_t               sts;
  logic                            need_div;
  logic                            div_busy;
  logic                            in_ready;
  logic                            out_valid;
  logic [ifp_pkg::PROD_W-1:0]      div_dividend;
  logic [ifp_pkg::TIMER_W-1:0]     div_divisor;
  logic [ifp_pkg::PROD_W-1:0]      div_quotient;
  logic signed [ifp_pkg::DRIVE_W-1:0] drive_x10;
  logic                            drive_updated;
  logic [1:0]                      phase;
  logic [1:0]                      last_action;
  logic [15:0]                     fire_count;

  assign sts.need_div = need_div;
  assign sts.div_busy = div_busy;

  ifp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ifp_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .need_div          (need_div),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_mode           (in_ch.mode),
    .in_accel_sample   (in_ch.accel_sample),
    .in_allow          (in_ch.allow),
    .div_dividend      (div_dividend),
    .div_divisor       (div_divisor),
    .div_quotient      (div_quotient),
    .out_drive_x10     (drive_x10),
    .out_drive_updated (drive_updated),
    .out_phase         (phase),
    .out_last_action   (last_action),
    .out_fire_count    (fire_count)
  );

  ifp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid;
  assign out_ch.drive_x10     = drive_x10;
  assign out_ch.drive_updated = drive_updated;
  assign out_ch.phase         = phase;
  assign out_ch.last_action   = last_action;
  assign out_ch.fire_count    = fire_count;

endmodule
